>>> design/kvt_pkg.sv
// Shared types, constants and helpers for the key/value tag tokenizer.
`default_nettype none
package kvt_pkg;

  localparam int MAX_LEN_DEFAULT = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int CHAR_W = 16;
  localparam int POS_W = 12;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_EQUALS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR = 1'd1;

  localparam logic [CHAR_W-1:0] EQUALS_RESET = 16'd61;
  localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 16'd44;

  localparam logic [CHAR_W-1:0] CH_NUL = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_CR = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_LF = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_TAB = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;

  // result status codes
  localparam logic [1:0] ST_PAIR = 2'd0;
  localparam logic [1:0] ST_END = 2'd1;
  localparam logic [1:0] ST_OPEN_QUOTE = 2'd2;
  localparam logic [1:0] ST_NO_EQUALS = 2'd3;

  // quote kinds
  localparam logic [1:0] Q_NONE = 2'd0;
  localparam logic [1:0] Q_DOUBLE = 2'd1;
  localparam logic [1:0] Q_SINGLE = 2'd2;

  typedef enum logic [5:0] {
    PH_NAME_SKIP   = 6'b000001,
    PH_NAME        = 6'b000010,
    PH_VALUE_SKIP  = 6'b000100,
    PH_QUOTED      = 6'b001000,
    PH_AFTER_QUOTE = 6'b010000,
    PH_UNQUOTED    = 6'b100000
  } phase_t;

  // one record per input that causes results: a pair, an end, or both
  typedef struct packed {
    logic             pair;
    logic             fin;
    logic [1:0]       fin_status;
    logic [POS_W-1:0] name_begin;
    logic [POS_W-1:0] name_trim_end;
    logic [POS_W-1:0] value_begin;
    logic [POS_W-1:0] value_trim_end;
    logic [1:0]       quote;
    logic             overflow;
  } event_t;

  function automatic logic is_lead_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic logic is_trail_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);
  endfunction

endpackage
`default_nettype wire

>>> design/kvt_front.sv
// Front end: takes characters, runs the pair parser and emits result events.
`default_nettype none
module kvt_front #(
  parameter int MAX_LEN = kvt_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [kvt_pkg::CHAR_W-1:0]       ch,
  input  wire logic                             cfg_valid,
  input  wire logic [kvt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [kvt_pkg::CHAR_W-1:0]       cfg_data,
  input  wire logic                             queue_full,
  output logic                                  push,
  output kvt_pkg::event_t                       push_event
);

  localparam int CAP_INT = ((MAX_LEN < 4096) ? MAX_LEN : 4096) - 1;
  localparam logic [kvt_pkg::POS_W-1:0] POS_CAP = kvt_pkg::POS_W'(CAP_INT);

  logic [kvt_pkg::CHAR_W-1:0] equals_char;
  logic [kvt_pkg::CHAR_W-1:0] separator_char;

  kvt_pkg::phase_t            phase, phase_next;
  logic [kvt_pkg::POS_W-1:0]  position, position_next;
  logic [kvt_pkg::POS_W-1:0]  name_begin, name_begin_next;
  logic [kvt_pkg::POS_W-1:0]  name_trim_end, name_trim_end_next;
  logic [kvt_pkg::POS_W-1:0]  value_begin, value_begin_next;
  logic [kvt_pkg::POS_W-1:0]  value_trim_end, value_trim_end_next;
  logic [1:0]                 quote_kind, quote_kind_next;
  logic                       overflow_seen, overflow_seen_next;

  logic                       accept;
  logic                       at_cap;
  logic [kvt_pkg::POS_W-1:0]  pos_inc;
  logic                       emit_pair, emit_fin;
  logic [1:0]                 fin_status;
  logic                       close_quote;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;
  assign at_cap = (position >= POS_CAP);
  assign pos_inc = at_cap ? POS_CAP : position + 1'b1;
  assign close_quote = ((quote_kind == kvt_pkg::Q_DOUBLE) && (ch == kvt_pkg::CH_DQUOTE)) ||
                       ((quote_kind != kvt_pkg::Q_DOUBLE) && (ch == kvt_pkg::CH_SQUOTE));

  always_comb begin
    phase_next = phase;
    position_next = position;
    name_begin_next = name_begin;
    name_trim_end_next = name_trim_end;
    value_begin_next = value_begin;
    value_trim_end_next = value_trim_end;
    quote_kind_next = quote_kind;
    overflow_seen_next = overflow_seen;
    emit_pair = 1'b0;
    emit_fin = 1'b0;
    fin_status = kvt_pkg::ST_END;

    if (ch == kvt_pkg::CH_NUL) begin
      emit_fin = 1'b1;
      unique case (phase) inside
        kvt_pkg::PH_NAME: fin_status = kvt_pkg::ST_NO_EQUALS;
        kvt_pkg::PH_QUOTED: fin_status = kvt_pkg::ST_OPEN_QUOTE;
        kvt_pkg::PH_VALUE_SKIP: begin
          // empty value at end of string
          value_begin_next = position;
          value_trim_end_next = position;
          quote_kind_next = kvt_pkg::Q_NONE;
          emit_pair = 1'b1;
        end
        kvt_pkg::PH_AFTER_QUOTE, kvt_pkg::PH_UNQUOTED: emit_pair = 1'b1;
        default: fin_status = kvt_pkg::ST_END;
      endcase
    end else begin
      unique case (phase)
        kvt_pkg::PH_NAME: begin
          if (ch == equals_char) begin
            phase_next = kvt_pkg::PH_VALUE_SKIP;
          end else if (!kvt_pkg::is_trail_ws(ch)) begin
            name_trim_end_next = pos_inc;
          end
        end
        kvt_pkg::PH_VALUE_SKIP: begin
          if (kvt_pkg::is_lead_ws(ch)) begin
            phase_next = phase;
          end else if ((ch == kvt_pkg::CH_DQUOTE) || (ch == kvt_pkg::CH_SQUOTE)) begin
            quote_kind_next = (ch == kvt_pkg::CH_DQUOTE) ? kvt_pkg::Q_DOUBLE : kvt_pkg::Q_SINGLE;
            value_begin_next = pos_inc;
            value_trim_end_next = pos_inc;
            phase_next = kvt_pkg::PH_QUOTED;
          end else if (ch == separator_char) begin
            quote_kind_next = kvt_pkg::Q_NONE;
            value_begin_next = position;
            value_trim_end_next = position;
            emit_pair = 1'b1;
            phase_next = kvt_pkg::PH_NAME_SKIP;
          end else begin
            quote_kind_next = kvt_pkg::Q_NONE;
            value_begin_next = position;
            value_trim_end_next = pos_inc;
            phase_next = kvt_pkg::PH_UNQUOTED;
          end
        end
        kvt_pkg::PH_QUOTED: begin
          if (close_quote) begin
            value_trim_end_next = position;
            phase_next = kvt_pkg::PH_AFTER_QUOTE;
          end
        end
        kvt_pkg::PH_AFTER_QUOTE: begin
          if (ch == separator_char) begin
            emit_pair = 1'b1;
            phase_next = kvt_pkg::PH_NAME_SKIP;
          end
        end
        kvt_pkg::PH_UNQUOTED: begin
          if (ch == separator_char) begin
            emit_pair = 1'b1;
            phase_next = kvt_pkg::PH_NAME_SKIP;
          end else if (!kvt_pkg::is_trail_ws(ch)) begin
            value_trim_end_next = pos_inc;
          end
        end
        default: begin
          if (kvt_pkg::is_lead_ws(ch)) begin
            phase_next = kvt_pkg::PH_NAME_SKIP;
          end else begin
            name_begin_next = position;
            if (ch == equals_char) begin
              name_trim_end_next = position;
              phase_next = kvt_pkg::PH_VALUE_SKIP;
            end else begin
              name_trim_end_next = pos_inc;
              phase_next = kvt_pkg::PH_NAME;
            end
          end
        end
      endcase
      if (at_cap) begin
        overflow_seen_next = 1'b1;
      end else begin
        position_next = position + 1'b1;
      end
    end
  end

  // event carries the pair fields as updated by this character
  always_comb begin
    push = accept && (emit_pair || emit_fin);
    push_event.pair = emit_pair;
    push_event.fin = emit_fin;
    push_event.fin_status = fin_status;
    push_event.name_begin = name_begin_next;
    push_event.name_trim_end = name_trim_end_next;
    push_event.value_begin = value_begin_next;
    push_event.value_trim_end = value_trim_end_next;
    push_event.quote = quote_kind_next;
    push_event.overflow = overflow_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      equals_char <= kvt_pkg::EQUALS_RESET;
      separator_char <= kvt_pkg::SEPARATOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kvt_pkg::REG_EQUALS: equals_char <= cfg_data;
        kvt_pkg::REG_SEPARATOR: separator_char <= cfg_data;
        default: equals_char <= equals_char;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && emit_fin)) begin
      phase <= kvt_pkg::PH_NAME_SKIP;
      position <= '0;
      name_begin <= '0;
      name_trim_end <= '0;
      value_begin <= '0;
      value_trim_end <= '0;
      quote_kind <= kvt_pkg::Q_NONE;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      position <= position_next;
      name_begin <= name_begin_next;
      name_trim_end <= name_trim_end_next;
      value_begin <= value_begin_next;
      value_trim_end <= value_trim_end_next;
      quote_kind <= quote_kind_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule
`default_nettype wire

>>> design/kvt_queue.sv
// Small event queue between the parser front end and the result back end.
`default_nettype none
module kvt_queue #(
  parameter int DEPTH = kvt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire kvt_pkg::event_t  push_event,
  input  wire logic             pop,
  output kvt_pkg::event_t       head,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  kvt_pkg::event_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full = (count == FULL_COUNT);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/kvt_back.sv
// Back end: expands queued events into result transfers on an output register.
`default_nettype none
module kvt_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire kvt_pkg::event_t            head,
  input  wire logic                       empty,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic [kvt_pkg::POS_W-1:0]       name_start,
  output logic [kvt_pkg::POS_W-1:0]       name_chars,
  output logic [kvt_pkg::POS_W-1:0]       value_start,
  output logic [kvt_pkg::POS_W-1:0]       value_chars,
  output logic [1:0]                      quoted,
  output logic                            overflow,
  output logic                            last
);

  logic                      second;    // pair already sent, end result next
  logic                      load;
  logic                      give_pair;
  logic                      two_results;
  logic [kvt_pkg::POS_W-1:0] nl, vl;

  assign load = !out_valid || out_ready;
  assign two_results = head.pair && head.fin;
  assign give_pair = head.pair && !second;
  assign pop = load && !empty && !(two_results && !second);

  assign nl = (head.name_trim_end >= head.name_begin) ?
              head.name_trim_end - head.name_begin : '0;
  assign vl = (head.value_trim_end >= head.value_begin) ?
              head.value_trim_end - head.value_begin : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        second <= two_results && !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      overflow <= head.overflow;
      if (give_pair) begin
        status <= kvt_pkg::ST_PAIR;
        name_start <= head.name_begin;
        name_chars <= nl;
        value_start <= head.value_begin;
        value_chars <= vl;
        quoted <= head.quote;
        last <= !head.fin;
      end else begin
        status <= head.fin_status;
        name_start <= '0;
        name_chars <= '0;
        value_start <= '0;
        value_chars <= '0;
        quoted <= kvt_pkg::Q_NONE;
        last <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/key_value_tag_tokenizer.sv
// Top level of the key/value tag tokenizer: front parser, event queue, result back end.
// Input channel (in_valid/in_ready/ch): one 16-bit character per transfer; a zero
//   ends the string and the next character is offset zero again.
// Output channel (out_valid/out_ready): one result per transfer, either a pair
//   (status 0) with name/value offsets and lengths or an end status (1 clean,
//   2 open quote, 3 text without equals); last marks the final result of a character.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): equals_char at index 0,
//   separator_char at index 1; always ready, write only while idle.
// Path: a result's event enters the queue, then loads into the output register.
// Throughput: one character per cycle while in_ready is high; the parser state is
//   updated per accepted character; a zero closing a pair yields two transfers.
// Reset: rst (synchronous) empties the queue, drops out_valid, returns the parser
//   to skipping whitespace at offset zero and loads '=' and ',' as delimiters.
// Stall: while out_ready is low the output register holds; up to QUEUE_DEPTH events
//   queue behind it, then in_ready drops until the back end drains.
`default_nettype none
module key_value_tag_tokenizer #(
  parameter int MAX_LEN = kvt_pkg::MAX_LEN_DEFAULT,
  parameter int QUEUE_DEPTH = kvt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [kvt_pkg::CHAR_W-1:0]       ch,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            status,
  output logic [kvt_pkg::POS_W-1:0]             name_start,
  output logic [kvt_pkg::POS_W-1:0]             name_chars,
  output logic [kvt_pkg::POS_W-1:0]             value_start,
  output logic [kvt_pkg::POS_W-1:0]             value_chars,
  output logic [1:0]                            quoted,
  output logic                                  overflow,
  output logic                                  last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [kvt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [kvt_pkg::CHAR_W-1:0]       cfg_data
);

  kvt_pkg::event_t push_event;
  kvt_pkg::event_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  // registers are plain flops, so a write never has to wait
  assign cfg_ready = 1'b1;

  // parser: one character per cycle unless the queue is full, pushes an event when results are due
  kvt_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ch(ch),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .queue_full(full),
    .push(push),
    .push_event(push_event)
  );

  // decouples parser from output stalls
  kvt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_event(push_event),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  // expands each event into one or two result transfers
  kvt_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .name_start(name_start),
    .name_chars(name_chars),
    .value_start(value_start),
    .value_chars(value_chars),
    .quoted(quoted),
    .overflow(overflow),
    .last(last)
  );

endmodule
`default_nettype wire

>>> dv/kvt_tb_pkg.sv
// Scoreboard for the key/value tag tokenizer: tracks the parse and checks each result.
`timescale 1ns / 1ps
package kvt_tb_pkg;

  // offsets saturate one short of the string length limit, at most the 12-bit top
  localparam logic [kvt_pkg::POS_W-1:0] POS_CAP = kvt_pkg::POS_W'(
      (kvt_pkg::MAX_LEN_DEFAULT < 4096) ? kvt_pkg::MAX_LEN_DEFAULT - 1 : 4095);

  typedef struct packed {
    logic [1:0]                status;
    logic [kvt_pkg::POS_W-1:0] name_start;
    logic [kvt_pkg::POS_W-1:0] name_chars;
    logic [kvt_pkg::POS_W-1:0] value_start;
    logic [kvt_pkg::POS_W-1:0] value_chars;
    logic [1:0]                quoted;
    logic                      overflow;
    logic                      last;
  } token_result_t;

  class token_scoreboard;
    logic [kvt_pkg::CHAR_W-1:0] equals_char;
    logic [kvt_pkg::CHAR_W-1:0] separator_char;
    kvt_pkg::phase_t            phase;
    logic [kvt_pkg::POS_W-1:0]  pos;
    logic [kvt_pkg::POS_W-1:0]  name_begin;
    logic [kvt_pkg::POS_W-1:0]  name_end;
    logic [kvt_pkg::POS_W-1:0]  value_begin;
    logic [kvt_pkg::POS_W-1:0]  value_end;
    logic [1:0]                 quote;
    logic                       ovf;
    token_result_t              due_results[$];
    int                         mismatches;
    int                         results_seen;

    function new();
      equals_char = kvt_pkg::EQUALS_RESET;
      separator_char = kvt_pkg::SEPARATOR_RESET;
      mismatches = 0;
      results_seen = 0;
      restart();
    endfunction

    function void restart();
      phase = kvt_pkg::PH_NAME_SKIP;
      pos = '0;
      name_begin = '0;
      name_end = '0;
      value_begin = '0;
      value_end = '0;
      quote = kvt_pkg::Q_NONE;
      ovf = 1'b0;
    endfunction

    function void set_register(logic [kvt_pkg::CFG_INDEX_W-1:0] idx,
                               logic [kvt_pkg::CHAR_W-1:0] data);
      if (idx == kvt_pkg::REG_EQUALS) begin
        equals_char = data;
      end else if (idx == kvt_pkg::REG_SEPARATOR) begin
        separator_char = data;
      end
    endfunction

    static function bit lead_space(logic [kvt_pkg::CHAR_W-1:0] c);
      return c == kvt_pkg::CH_SPACE || c == kvt_pkg::CH_CR || c == kvt_pkg::CH_LF ||
             c == kvt_pkg::CH_TAB;
    endfunction

    // LF survives the trailing trim
    static function bit trail_space(logic [kvt_pkg::CHAR_W-1:0] c);
      return c == kvt_pkg::CH_SPACE || c == kvt_pkg::CH_CR || c == kvt_pkg::CH_TAB;
    endfunction

    static function logic [kvt_pkg::POS_W-1:0] advance(logic [kvt_pkg::POS_W-1:0] p);
      return (p < POS_CAP) ? p + 1'b1 : POS_CAP;
    endfunction

    function void add_result(logic [1:0] st, bit with_pair, bit is_last);
      token_result_t r;
      r = '0;
      r.status = st;
      if (with_pair) begin
        r.name_start = name_begin;
        r.name_chars = (name_end >= name_begin) ? name_end - name_begin : '0;
        r.value_start = value_begin;
        r.value_chars = (value_end >= value_begin) ? value_end - value_begin : '0;
        r.quoted = quote;
      end
      r.overflow = ovf;
      r.last = is_last;
      due_results.push_back(r);
    endfunction

    // advance the parse by one accepted character and queue what it yields
    function void parse_char(logic [kvt_pkg::CHAR_W-1:0] c);
      logic [kvt_pkg::POS_W-1:0] p;
      p = pos;
      if (c == kvt_pkg::CH_NUL) begin
        case (phase) inside
          kvt_pkg::PH_NAME: add_result(kvt_pkg::ST_NO_EQUALS, 1'b0, 1'b1);
          kvt_pkg::PH_QUOTED: add_result(kvt_pkg::ST_OPEN_QUOTE, 1'b0, 1'b1);
          kvt_pkg::PH_VALUE_SKIP: begin
            value_begin = p;
            value_end = p;
            quote = kvt_pkg::Q_NONE;
            add_result(kvt_pkg::ST_PAIR, 1'b1, 1'b0);
            add_result(kvt_pkg::ST_END, 1'b0, 1'b1);
          end
          kvt_pkg::PH_AFTER_QUOTE, kvt_pkg::PH_UNQUOTED: begin
            add_result(kvt_pkg::ST_PAIR, 1'b1, 1'b0);
            add_result(kvt_pkg::ST_END, 1'b0, 1'b1);
          end
          default: add_result(kvt_pkg::ST_END, 1'b0, 1'b1);
        endcase
        restart();
        return;
      end
      case (phase)
        kvt_pkg::PH_NAME: begin
          if (c == equals_char) begin
            phase = kvt_pkg::PH_VALUE_SKIP;
          end else if (!trail_space(c)) begin
            name_end = advance(p);
          end
        end
        kvt_pkg::PH_VALUE_SKIP: begin
          if (!lead_space(c)) begin
            if (c == kvt_pkg::CH_DQUOTE || c == kvt_pkg::CH_SQUOTE) begin
              quote = (c == kvt_pkg::CH_DQUOTE) ? kvt_pkg::Q_DOUBLE : kvt_pkg::Q_SINGLE;
              value_begin = advance(p);
              value_end = value_begin;
              phase = kvt_pkg::PH_QUOTED;
            end else if (c == separator_char) begin
              quote = kvt_pkg::Q_NONE;
              value_begin = p;
              value_end = p;
              add_result(kvt_pkg::ST_PAIR, 1'b1, 1'b1);
              phase = kvt_pkg::PH_NAME_SKIP;
            end else begin
              quote = kvt_pkg::Q_NONE;
              value_begin = p;
              value_end = advance(p);
              phase = kvt_pkg::PH_UNQUOTED;
            end
          end
        end
        kvt_pkg::PH_QUOTED: begin
          if ((quote == kvt_pkg::Q_DOUBLE && c == kvt_pkg::CH_DQUOTE) ||
              (quote != kvt_pkg::Q_DOUBLE && c == kvt_pkg::CH_SQUOTE)) begin
            value_end = p;
            phase = kvt_pkg::PH_AFTER_QUOTE;
          end
        end
        kvt_pkg::PH_AFTER_QUOTE: begin
          if (c == separator_char) begin
            add_result(kvt_pkg::ST_PAIR, 1'b1, 1'b1);
            phase = kvt_pkg::PH_NAME_SKIP;
          end
        end
        kvt_pkg::PH_UNQUOTED: begin
          if (c == separator_char) begin
            add_result(kvt_pkg::ST_PAIR, 1'b1, 1'b1);
            phase = kvt_pkg::PH_NAME_SKIP;
          end else if (!trail_space(c)) begin
            value_end = advance(p);
          end
        end
        default: begin
          if (lead_space(c)) begin
            phase = kvt_pkg::PH_NAME_SKIP;
          end else begin
            name_begin = p;
            if (c == equals_char) begin
              name_end = p;
              phase = kvt_pkg::PH_VALUE_SKIP;
            end else begin
              name_end = advance(p);
              phase = kvt_pkg::PH_NAME;
            end
          end
        end
      endcase
      if (p >= POS_CAP) begin
        ovf = 1'b1;
      end else begin
        pos = p + 1'b1;
      end
    endfunction

    task report_mismatch(string field, longint got_v, longint want_v);
      mismatches++;
      $display("[%0t] result %0d %s: got %0d expected %0d",
               $time, results_seen, field, got_v, want_v);
    endtask

    task check_result(token_result_t got);
      token_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected, status", got.status, -1);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.name_start !== want.name_start)
        report_mismatch("name_start", got.name_start, want.name_start);
      if (got.name_chars !== want.name_chars)
        report_mismatch("name_chars", got.name_chars, want.name_chars);
      if (got.value_start !== want.value_start)
        report_mismatch("value_start", got.value_start, want.value_start);
      if (got.value_chars !== want.value_chars)
        report_mismatch("value_chars", got.value_chars, want.value_chars);
      if (got.quoted !== want.quoted) report_mismatch("quoted", got.quoted, want.quoted);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", got.overflow, want.overflow);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

endpackage

>>> dv/tb_top.sv
// Testbench top for the key/value tag tokenizer: stimulus, handshakes and the final verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  // results pass the event queue and the output register; the settle time covers that pipe
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 70;
  localparam int NUM_PHASES = 6;
  // roughly 600 characters, with stalled results and the long hold, stay under this
  localparam int CYCLE_LIMIT = 50000;
  localparam logic [kvt_pkg::CHAR_W-1:0] LETTER_A = 16'h0061;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [kvt_pkg::CHAR_W-1:0]      ch = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      status;
  logic [kvt_pkg::POS_W-1:0]       name_start;
  logic [kvt_pkg::POS_W-1:0]       name_chars;
  logic [kvt_pkg::POS_W-1:0]       value_start;
  logic [kvt_pkg::POS_W-1:0]       value_chars;
  logic [1:0]                      quoted;
  logic                            overflow;
  logic                            last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [kvt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [kvt_pkg::CHAR_W-1:0]      cfg_data = '0;

  kvt_tb_pkg::token_scoreboard tracker;
  logic [kvt_pkg::CHAR_W-1:0]  char_stream[$];   // characters waiting to be sent
  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          hold_requests = 0;   // bumped by the stimulus, served by the receiver
  int                          cycle_count = 0;

  key_value_tag_tokenizer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .name_start  (name_start),
    .name_chars  (name_chars),
    .value_start (value_start),
    .value_chars (value_chars),
    .quoted      (quoted),
    .overflow    (overflow),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: check each transfer with the values from before the edge, then
  // pick the next out_ready. A hold request forces a long stall counted here.
  always @(posedge clk) begin : result_side
    kvt_tb_pkg::token_result_t got;
    int                        hold_left;
    int                        holds_served;
    if (!rst && out_valid && out_ready) begin
      got.status = status;
      got.name_start = name_start;
      got.name_chars = name_chars;
      got.value_start = value_start;
      got.value_chars = value_chars;
      got.quoted = quoted;
      got.overflow = overflow;
      got.last = last;
      tracker.check_result(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One character transfer. Random idle cycles go in front; valid then stays up
  // until in_ready is seen at an edge, and the accepted character feeds the tracker.
  task automatic send_char(input logic [kvt_pkg::CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (!in_ready);
    tracker.parse_char(c);
  endtask

  task automatic send_stream();
    while (char_stream.size() != 0) send_char(char_stream.pop_front());
  endtask

  // Drop valid and wait for every due result, then let the pipe settle: the
  // last characters may have caused no result yet still be in flight.
  task automatic await_results();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes never lower and raise it in one step.
  task automatic write_reg(input logic [kvt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [kvt_pkg::CHAR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
  endtask

  task automatic configure(input logic [kvt_pkg::CHAR_W-1:0] eq_char,
                           input logic [kvt_pkg::CHAR_W-1:0] sep_char);
    write_reg(kvt_pkg::REG_EQUALS, eq_char);
    write_reg(kvt_pkg::REG_SEPARATOR, sep_char);
    cfg_valid <= 1'b0;
  endtask

  // Shorthand for directed text: ~ tab, ^ CR, | LF, # 0xFFFF, @ the terminating zero.
  function automatic void add_text(input string s);
    logic [kvt_pkg::CHAR_W-1:0] c;
    for (int i = 0; i < s.len(); i++) begin
      case (s[i])
        "~": c = kvt_pkg::CH_TAB;
        "^": c = kvt_pkg::CH_CR;
        "|": c = kvt_pkg::CH_LF;
        "#": c = 16'hFFFF;
        "@": c = kvt_pkg::CH_NUL;
        default: c = kvt_pkg::CHAR_W'(s[i]);
      endcase
      char_stream.push_back(c);
    end
  endfunction

  function automatic logic [kvt_pkg::CHAR_W-1:0] pick_lead_ws();
    case ($urandom_range(3))
      0: return kvt_pkg::CH_SPACE;
      1: return kvt_pkg::CH_CR;
      2: return kvt_pkg::CH_LF;
      default: return kvt_pkg::CH_TAB;
    endcase
  endfunction

  function automatic logic [kvt_pkg::CHAR_W-1:0] pick_trail_ws();
    case ($urandom_range(2))
      0: return kvt_pkg::CH_SPACE;
      1: return kvt_pkg::CH_CR;
      default: return kvt_pkg::CH_TAB;
    endcase
  endfunction

  // mostly letters, now and then any nonzero code so every bit of ch moves
  function automatic logic [kvt_pkg::CHAR_W-1:0] pick_text_char();
    if ($urandom_range(4) == 0) return kvt_pkg::CHAR_W'($urandom_range(65535, 1));
    return LETTER_A + kvt_pkg::CHAR_W'($urandom_range(25));
  endfunction

  // inside quotes: delimiters and the other quote are plain text; either quote may be picked
  function automatic logic [kvt_pkg::CHAR_W-1:0] pick_quoted_char();
    case ($urandom_range(6))
      0: return tracker.separator_char;
      1: return tracker.equals_char;
      2: return ($urandom_range(1) != 0) ? kvt_pkg::CH_DQUOTE : kvt_pkg::CH_SQUOTE;
      3: return pick_lead_ws();
      default: return pick_text_char();
    endcase
  endfunction

  // One string with random content: mostly well-formed pairs, ending cleanly,
  // with an open quote, with a bare name, or with noise.
  function automatic void build_string();
    int                         pairs;
    logic [kvt_pkg::CHAR_W-1:0] q;
    pairs = $urandom_range(3);
    for (int k = 0; k < pairs; k++) begin
      repeat ($urandom_range(2)) char_stream.push_back(pick_lead_ws());
      repeat ($urandom_range(4)) char_stream.push_back(pick_text_char());
      repeat ($urandom_range(1)) char_stream.push_back(pick_trail_ws());
      char_stream.push_back(tracker.equals_char);
      repeat ($urandom_range(2)) char_stream.push_back(pick_lead_ws());
      case ($urandom_range(3)) inside
        0: begin
          repeat ($urandom_range(5, 1))
            char_stream.push_back(($urandom_range(3) == 0) ? pick_lead_ws() : pick_text_char());
          repeat ($urandom_range(2)) char_stream.push_back(pick_trail_ws());
        end
        1, 2: begin
          q = ($urandom_range(1) != 0) ? kvt_pkg::CH_DQUOTE : kvt_pkg::CH_SQUOTE;
          char_stream.push_back(q);
          repeat ($urandom_range(4)) char_stream.push_back(pick_quoted_char());
          char_stream.push_back(q);
          repeat ($urandom_range(2)) char_stream.push_back(pick_text_char());
        end
        default: ;   // empty value
      endcase
      if (k + 1 < pairs) char_stream.push_back(tracker.separator_char);
    end
    case ($urandom_range(9))
      7: begin   // value quote never closed
        char_stream.push_back(pick_text_char());
        char_stream.push_back(tracker.equals_char);
        char_stream.push_back(($urandom_range(1) != 0) ? kvt_pkg::CH_DQUOTE : kvt_pkg::CH_SQUOTE);
        repeat ($urandom_range(3)) char_stream.push_back(pick_text_char());
      end
      8: repeat ($urandom_range(4, 1)) char_stream.push_back(pick_text_char());
      9: repeat ($urandom_range(8, 1))
           char_stream.push_back(kvt_pkg::CHAR_W'($urandom_range(65535, 1)));
      default: if ($urandom_range(3) == 0) char_stream.push_back(tracker.separator_char);
    endcase
    char_stream.push_back(kvt_pkg::CH_NUL);
  endfunction

  initial begin
    int sent;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sender idles 12 in 100, receiver 58 in 100
    send_idle_pct = 12;
    recv_idle_pct = 58;

    // Directed strings under the reset delimiters:
    //   leading tab, name trimmed of CR, double-quoted value with junk after the
    //   quote, then an empty name with a single quote left open;
    //   max code as a name character, LF skipped before a value, empty value at
    //   a separator, clean end from the name skip;
    //   bare name at the end;
    //   LF kept in an unquoted value, empty value at the zero (pair plus end).
    add_text("~k^=\"v\"z,='w@");
    add_text("#x =|,@");
    add_text("a@");
    add_text("a=b|,=@");
    send_stream();

    // Random phases, each under its own delimiters, written only once drained.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      await_results();
      case (ph)
        0: configure(16'h003B, 16'h0026);   // ';' and '&'
        1: configure(16'h0001, 16'hFFFF);
        2: configure(16'hFFFF, 16'h0001);
        3: configure(kvt_pkg::CHAR_W'($urandom_range(65535, 1)),
                     kvt_pkg::CHAR_W'($urandom_range(65535, 1)));
        // quote as equals, blank as separator: skip and quote checks go first
        4: configure(kvt_pkg::CH_DQUOTE, kvt_pkg::CH_SPACE);
        default: configure(kvt_pkg::EQUALS_RESET, kvt_pkg::SEPARATOR_RESET);
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_string();
        sent += char_stream.size();
        send_stream();
      end
    end

    // Back pressure: the receiver stalls for a long stretch while a burst of
    // pairs keeps coming, so the result queue fills and in_ready drops.
    hold_requests++;
    repeat (24) add_text("k=v,");
    add_text("@");
    send_stream();

    await_results();
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/kvt_pkg.sv
design/kvt_front.sv
design/kvt_queue.sv
design/kvt_back.sv
design/key_value_tag_tokenizer.sv
dv/kvt_tb_pkg.sv
dv/tb_top.sv
